// ----- sv/mte_pkg.sv -----
// ----------------------------------------------------------------------------
// mte_pkg
// Types and constants shared by the markup tag content extractor modules.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int unsigned MaxName  = 8;
  localparam int unsigned NameIdxW = 4;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [7:0] CharLt      = 8'h3C;
  localparam logic [7:0] CharGt      = 8'h3E;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharNewline = 8'h0A;

  localparam logic [CfgIdxW-1:0] RegTagChars = 8'd0;
  localparam logic [CfgIdxW-1:0] RegTagLen   = 8'd1;

  typedef enum logic [1:0] {
    MODE_OUTSIDE = 2'd0,
    MODE_NAME    = 2'd1,
    MODE_ATTR    = 2'd2,
    MODE_CONTENT = 2'd3
  } scan_mode_t;

  // one accepted byte's worth of output work
  typedef struct packed {
    logic       emit_byte;
    logic       emit_end;
    logic [7:0] data;
  } op_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- sv/mte_front.sv -----
// ----------------------------------------------------------------------------
// mte_front
// Holds the tag configuration, tracks the scan state byte by byte and turns
// each accepted byte that yields result items into an output operation.
// ----------------------------------------------------------------------------
module mte_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [7:0]                    in_byte,
  input  logic                          end_of_stream,
  input  logic                          cfg_write,
  input  logic [mte_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [63:0]                   cfg_data,
  output logic                          op_valid,
  output mte_pkg::op_t                  op
);

  logic [63:0]                        tag_chars;
  logic [3:0]                         tag_len;
  mte_pkg::scan_mode_t                scan_mode, scan_mode_next;
  logic [mte_pkg::NameIdxW-1:0]       name_index, name_index_next;
  logic                               name_mismatch, name_mismatch_next;
  logic                               head_matched, head_matched_next;
  logic [7:0]                         want;
  logic                               name_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_chars <= '0;
      tag_len   <= 4'd1;
    end else if (cfg_write) begin
      if (cfg_index == mte_pkg::RegTagChars) begin
        tag_chars <= cfg_data;
      end else if (cfg_index == mte_pkg::RegTagLen) begin
        tag_len <= cfg_data[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= mte_pkg::MODE_OUTSIDE;
      name_index    <= '0;
      name_mismatch <= 1'b0;
      head_matched  <= 1'b0;
    end else if (take) begin
      scan_mode     <= scan_mode_next;
      name_index    <= name_index_next;
      name_mismatch <= name_mismatch_next;
      head_matched  <= head_matched_next;
    end
  end

  assign want    = tag_chars[{name_index[2:0], 3'b000} +: 8];
  assign name_ok = !name_mismatch && (name_index == tag_len);

  always_comb begin
    scan_mode_next     = scan_mode;
    name_index_next    = name_index;
    name_mismatch_next = name_mismatch;
    head_matched_next  = head_matched;
    op.emit_byte       = 1'b0;
    op.emit_end        = 1'b0;
    op.data            = in_byte;
    case (scan_mode)
      mte_pkg::MODE_OUTSIDE: begin
        if (in_byte == mte_pkg::CharLt) begin
          scan_mode_next     = mte_pkg::MODE_NAME;
          name_index_next    = '0;
          name_mismatch_next = 1'b0;
          head_matched_next  = 1'b0;
        end
      end
      mte_pkg::MODE_NAME: begin
        if (in_byte == mte_pkg::CharSpace) begin
          head_matched_next = name_ok;
          scan_mode_next    = mte_pkg::MODE_ATTR;
        end else if (in_byte == mte_pkg::CharGt) begin
          scan_mode_next = name_ok ? mte_pkg::MODE_CONTENT : mte_pkg::MODE_OUTSIDE;
        end else if (name_index >= mte_pkg::NameIdxW'(mte_pkg::MaxName)) begin
          name_mismatch_next = 1'b1;
        end else begin
          if (name_index >= tag_len ||
              mte_pkg::fold_case(in_byte) != mte_pkg::fold_case(want)) begin
            name_mismatch_next = 1'b1;
          end
          name_index_next = name_index + 1'b1;
        end
      end
      mte_pkg::MODE_ATTR: begin
        if (in_byte == mte_pkg::CharGt) begin
          scan_mode_next = head_matched ? mte_pkg::MODE_CONTENT : mte_pkg::MODE_OUTSIDE;
        end
      end
      mte_pkg::MODE_CONTENT: begin
        if (in_byte == mte_pkg::CharLt) begin
          op.emit_end        = 1'b1;
          scan_mode_next     = mte_pkg::MODE_NAME;
          name_index_next    = '0;
          name_mismatch_next = 1'b0;
          head_matched_next  = 1'b0;
        end else begin
          op.emit_byte = 1'b1;
        end
      end
      default: begin
        scan_mode_next = mte_pkg::MODE_OUTSIDE;
      end
    endcase
    if (end_of_stream) begin
      if (scan_mode_next == mte_pkg::MODE_CONTENT) begin
        op.emit_end = 1'b1;
      end
      scan_mode_next     = mte_pkg::MODE_OUTSIDE;
      name_index_next    = '0;
      name_mismatch_next = 1'b0;
      head_matched_next  = 1'b0;
    end
    op_valid = take && (op.emit_byte || op.emit_end);
  end

endmodule

// ----- sv/mte_queue.sv -----
// ----------------------------------------------------------------------------
// mte_queue
// Short register queue of output operations between front and back.
// ----------------------------------------------------------------------------
module mte_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  mte_pkg::op_t wr_op,
  input  logic         rd_en,
  output mte_pkg::op_t rd_op,
  output logic         not_empty,
  output logic         is_full
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  mte_pkg::op_t    slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_op     = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign is_full   = (count == CntW'(DEPTH));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    is_full |-> !wr_en || rd_en)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> not_empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ----- sv/mte_back.sv -----
// ----------------------------------------------------------------------------
// mte_back
// Takes operations from the queue and presents their result items one at a
// time from an output register.
// ----------------------------------------------------------------------------
module mte_back (
  input  logic         clk,
  input  logic         rst,
  input  mte_pkg::op_t q_op,
  input  logic         q_not_empty,
  output logic         q_rd,
  input  logic         pop,
  output logic         empty,
  output logic [7:0]   out_byte,
  output logic         record_end
);

  logic       byte_pend;
  logic       end_pend;
  logic [7:0] held_byte;
  logic       slot_free;

  assign empty     = !(byte_pend || end_pend);
  assign slot_free = empty || (pop && !(byte_pend && end_pend));
  assign q_rd      = slot_free && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pend <= 1'b0;
      end_pend  <= 1'b0;
    end else if (q_rd) begin
      byte_pend <= q_op.emit_byte;
      end_pend  <= q_op.emit_end;
    end else if (slot_free) begin
      byte_pend <= 1'b0;
      end_pend  <= 1'b0;
    end else if (pop) begin
      byte_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      held_byte <= q_op.data;
    end
  end

  assign out_byte   = byte_pend ? held_byte : mte_pkg::CharNewline;
  assign record_end = !byte_pend;

endmodule

// ----- sv/markup_tag_content_extractor.sv -----
// ----------------------------------------------------------------------------
// markup_tag_content_extractor
// Extracts the text of every tag whose name matches the configured name.
//
//   channel   direction  handshake              payload
//   input     in         push / full            in_byte, end_of_stream
//   result    out        empty / pop            out_byte, record_end
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is accepted per cycle while full is low; the scan state registers
// on each accepted byte. A byte yields zero, one or two result items, delivered
// one per cycle from the output register while pop is held; the operation queue
// (QUEUE_DEPTH entries) absorbs bursts. Each operation passes through the queue
// into the output register. Reset clears scan state, queue and output;
// tag_chars = 0, tag_len = 1. full rises when the queue fills: pop held low,
// or two-item bytes outpacing pop.
module markup_tag_content_extractor #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_byte,
  input  logic                        end_of_stream,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_byte,
  output logic                        record_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mte_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                 cfg_data
);

  logic         take;
  logic         op_valid;
  mte_pkg::op_t front_op;
  mte_pkg::op_t q_op;
  logic         q_not_empty;
  logic         q_rd;

  assign cfg_ready = 1'b1;
  assign take      = push && !full;

  mte_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op_valid      (op_valid),
    .op            (front_op)
  );

  mte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (op_valid),
    .wr_op     (front_op),
    .rd_en     (q_rd),
    .rd_op     (q_op),
    .not_empty (q_not_empty),
    .is_full   (full)
  );

  mte_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_op        (q_op),
    .q_not_empty (q_not_empty),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .record_end  (record_end)
  );

`ifndef SYNTHESIS
  a_end_is_newline: assert property (@(posedge clk) disable iff (rst)
    (!empty && record_end) |-> (out_byte == mte_pkg::CharNewline))
    else $error("record end without newline");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");
  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("queue full while output register idle");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of markup_tag_content_extractor. Directed markup covers
// name matching, spaces in tags, empty content and end of stream. Random
// streams of well-formed tags with random names, attributes and content, plus
// raw noise, follow under several tag settings. A scan model in the bench
// predicts every result item, and each popped item is compared in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 8;
  localparam int EndCycles    = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       closes;
  } text_item_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        push = 1'b0;
  logic                        full;
  logic [7:0]                  in_byte = '0;
  logic                        end_of_stream = 1'b0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [7:0]                  out_byte;
  logic                        record_end;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [mte_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]                 cfg_data = '0;

  text_item_t pending_text[$];
  int         send_idle_pct = 27;
  int         recv_idle_pct = 61;
  int         bytes_sent = 0;
  int         items_checked = 0;
  int         bad_items = 0;
  int         tag_loads = 0;
  int         cycle_count = 0;

  // scan model state and tag registers
  mte_pkg::scan_mode_t sc_mode = mte_pkg::MODE_OUTSIDE;
  logic [3:0] sc_idx = '0;
  logic       sc_miss = 1'b0;
  logic       sc_head = 1'b0;
  logic [63:0] cur_tag_chars = '0;
  logic [3:0]  cur_tag_len = 4'd1;

  markup_tag_content_extractor dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    text_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_text.size() == 0) begin
        $error("item with none pending: out_byte %h record_end %b", out_byte, record_end);
        bad_items++;
      end else begin
        want = pending_text.pop_front();
        items_checked++;
        if (out_byte !== want.ch) begin
          $error("out_byte: expected %h, got %h", want.ch, out_byte);
          bad_items++;
        end
        if (record_end !== want.closes) begin
          $error("record_end: expected %b, got %b", want.closes, record_end);
          bad_items++;
        end
      end
    end
  end

  function automatic logic [7:0] lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c | 8'h20;
    return c;
  endfunction

  function automatic logic name_hit();
    return !sc_miss && sc_idx == cur_tag_len;
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] c;
    c = 8'h41 + 8'($urandom_range(25));
    if ($urandom_range(1) == 1) c = c | 8'h20;
    return c;
  endfunction

  task automatic clear_scan(input mte_pkg::scan_mode_t m);
    sc_mode = m;
    sc_idx  = '0;
    sc_miss = 1'b0;
    sc_head = 1'b0;
  endtask

  task automatic add_text(input logic [7:0] b, input logic closes);
    text_item_t t;
    t.ch = b;
    t.closes = closes;
    pending_text.push_back(t);
  endtask

  task automatic track_markup(input logic [7:0] b, input logic eos);
    logic [7:0] want;
    case (sc_mode)
      mte_pkg::MODE_OUTSIDE: begin
        if (b == mte_pkg::CharLt) clear_scan(mte_pkg::MODE_NAME);
      end
      mte_pkg::MODE_NAME: begin
        if (b == mte_pkg::CharSpace) begin
          sc_head = name_hit();
          sc_mode = mte_pkg::MODE_ATTR;
        end else if (b == mte_pkg::CharGt) begin
          sc_mode = name_hit() ? mte_pkg::MODE_CONTENT : mte_pkg::MODE_OUTSIDE;
        end else if (sc_idx >= mte_pkg::MaxName) begin
          sc_miss = 1'b1;
        end else begin
          want = cur_tag_chars[8*sc_idx +: 8];
          if (sc_idx >= cur_tag_len || lower(b) != lower(want)) sc_miss = 1'b1;
          sc_idx = sc_idx + 4'd1;
        end
      end
      mte_pkg::MODE_ATTR: begin
        if (b == mte_pkg::CharGt) begin
          sc_mode = sc_head ? mte_pkg::MODE_CONTENT : mte_pkg::MODE_OUTSIDE;
        end
      end
      default: begin
        if (b == mte_pkg::CharLt) begin
          add_text(mte_pkg::CharNewline, 1'b1);
          clear_scan(mte_pkg::MODE_NAME);
        end else begin
          add_text(b, 1'b0);
        end
      end
    endcase
    if (eos) begin
      if (sc_mode == mte_pkg::MODE_CONTENT) add_text(mte_pkg::CharNewline, 1'b1);
      clear_scan(mte_pkg::MODE_OUTSIDE);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (full) @(posedge clk);
    track_markup(b, eos);
    bytes_sent++;
  endtask

  task automatic send_string(input string s, input logic eos_last);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], eos_last && i == s.len() - 1);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic accept_cfg();
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_tag(input logic [63:0] chars, input logic [3:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= mte_pkg::RegTagChars;
    cfg_data <= chars;
    accept_cfg();
    cur_tag_chars = chars;
    cfg_index <= mte_pkg::RegTagLen;
    cfg_data <= {$urandom, 28'($urandom), len};
    accept_cfg();
    cur_tag_len = len;
    // unused index, must be ignored
    cfg_index <= mte_pkg::CfgIdxW'($urandom_range((1 << mte_pkg::CfgIdxW) - 1,
                                                  mte_pkg::RegTagLen + 1));
    cfg_data <= {$urandom, $urandom};
    accept_cfg();
    cfg_valid <= 1'b0;
    tag_loads++;
  endtask

  task automatic send_element();
    logic [7:0] chunk[$];
    logic [7:0] c;
    logic       eos;
    int         kind, base, name_n, bad_at, pick, i;
    base = (cur_tag_len > mte_pkg::MaxName) ? mte_pkg::MaxName : cur_tag_len;
    kind = $urandom_range(5);
    bad_at = -1;
    case (kind)
      0: name_n = base;
      1: name_n = (base > 0) ? base - 1 : 0;
      2: name_n = base + 1;
      3: begin
        name_n = base;
        if (base > 0) bad_at = $urandom_range(base - 1);
      end
      4: name_n = $urandom_range(12, mte_pkg::MaxName + 1);
      default: name_n = $urandom_range(mte_pkg::MaxName);
    endcase
    chunk.push_back(mte_pkg::CharLt);
    for (i = 0; i < name_n; i++) begin
      if (kind == 5) begin
        do begin
          c = 8'($urandom);
        end while (c == mte_pkg::CharSpace || c == mte_pkg::CharGt);
      end else begin
        if (i < mte_pkg::MaxName) c = cur_tag_chars[8*i +: 8];
        else c = random_letter();
        if (i == bad_at) c = c ^ 8'h01;
        if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(1) == 1) begin
          c = c ^ 8'h20;
        end
      end
      chunk.push_back(c);
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      chunk.push_back(mte_pkg::CharGt);
    end else if (pick < 95) begin
      chunk.push_back(mte_pkg::CharSpace);
      repeat ($urandom_range(4)) begin
        do begin
          c = 8'($urandom);
        end while (c == mte_pkg::CharGt);
        chunk.push_back(c);
      end
      chunk.push_back(mte_pkg::CharGt);
    end
    if (pick < 95) begin
      repeat ($urandom_range(6)) begin
        do begin
          c = 8'($urandom);
        end while (c == mte_pkg::CharLt);
        chunk.push_back(c);
      end
    end
    eos = ($urandom_range(9) == 0);
    foreach (chunk[k]) send_byte(chunk[k], eos && k == chunk.size() - 1);
  endtask

  task automatic test_reset_tag();
    // reset tag is one zero character
    send_byte(mte_pkg::CharLt, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(mte_pkg::CharGt, 1'b0);
    send_string("k", 1'b1);
    drain();
  endtask

  task automatic test_basic_extraction();
    load_tag(64'h4261, 4'd2);
    send_string("<Ab>", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(mte_pkg::CharNewline, 1'b0);
    send_string("<AB z<>", 1'b0);
    send_string("<a<b>", 1'b0);
    send_string("<ab", 1'b1);
    drain();
  endtask

  task automatic test_empty_name();
    load_tag('0, 4'd0);
    send_string("<>q", 1'b1);
    drain();
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                     input int n);
    logic [63:0] chars;
    logic [3:0]  len;
    int          stop_at, reload_at, pick, i;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    stop_at = bytes_sent + n;
    reload_at = bytes_sent;
    while (bytes_sent < stop_at) begin
      if (bytes_sent >= reload_at) begin
        pick = $urandom_range(9);
        chars = '0;
        len = 4'($urandom_range(mte_pkg::MaxName, 1));
        if (pick == 0) len = '0;
        if (pick == 2) len = 4'($urandom_range(15, mte_pkg::MaxName + 1));
        for (i = 0; i < mte_pkg::MaxName && i < len; i++) begin
          chars[8*i +: 8] = random_letter();
        end
        if (pick == 1) begin
          len = 4'(mte_pkg::MaxName);
          chars = '1;
        end
        if (pick == 3) chars = {$urandom, $urandom};
        load_tag(chars, len);
        reload_at = bytes_sent + 50 + $urandom_range(40);
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(8, 1)) send_byte(8'($urandom), $urandom_range(15) == 0);
      end else begin
        send_element();
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_tag();
    test_basic_extraction();
    test_empty_name();
    test_random_traffic(27, 61, 340);
    test_random_traffic(61, 27, 340);
    test_random_traffic(0, 0, 340);
    repeat (EndCycles) @(posedge clk);
    $display("sent %0d stream bytes, checked %0d extracted items", bytes_sent, items_checked);
    $display("%0d tag settings, with empty, full-width and over-long names", tag_loads);
    if (bad_items == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
